// File: design/brp_pkg.sv
// Shared types and constants for the base relocation patcher.
// Used by brp_front, brp_queue, brp_back and base_relocation_patcher_core.
`timescale 1ns / 1ps
`default_nettype none

package brp_pkg;

  // Result kinds as seen on the output channel.
  localparam logic [1:0] KIND_PATCH = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  // Relocation entry types that produce a patch.
  localparam logic [3:0] TYPE_HIGH    = 4'd1;
  localparam logic [3:0] TYPE_LOW     = 4'd2;
  localparam logic [3:0] TYPE_HIGHLOW = 4'd3;
  localparam logic [3:0] TYPE_DIR64   = 4'd10;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_ADDRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFERRED_BASE = 2'd1;

  // Field widths.
  localparam int unsigned HW_W     = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned LEFT_W   = 31;

  // Command queue between the parser and the executor.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // How the addend is formed for a patch command.
  typedef enum logic [1:0] {
    CLS_HIGH,
    CLS_LOW,
    CLS_WIDE
  } brp_cls_t;

  // One request from the parser to the executor.
  typedef struct packed {
    logic [1:0]          kind;
    brp_cls_t            cls;
    logic [OFFSET_W-1:0] offset;
    logic [ADDR_W-1:0]   page;
  } brp_cmd_t;

  // Queue status toward the producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } brp_qstat_t;

endpackage

`default_nettype wire

// File: design/base_relocation_patcher_core.sv
// Top level of the base relocation patcher: configuration registers,
// parser front, command queue and executor. Depends on brp_pkg and submodules.
//
//   Port group | Direction | Handshake          | Carries
//   in_*       | input     | in_valid/in_stall  | one 16-bit table halfword
//   out_*      | output    | out_valid/out_stall| patch command or table end
//   cfg_*      | input     | cfg_valid/cfg_ready| register index and write data
//
// One halfword is taken per cycle while in_stall is low; in_stall rises only
// while the 4-entry command queue is full, which happens when out_stall holds
// the output back. The parser writes a request into the queue at the edge
// that takes its halfword; the executor then moves it to the output register.
// rst_n is synchronous and active low; after it the parser expects a page
// half and both registers read zero. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module base_relocation_patcher_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [brp_pkg::HW_W-1:0]       in_halfword,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [brp_pkg::ADDR_W-1:0]          out_patch_address,
  output logic [brp_pkg::ADDR_W-1:0]          out_addend,
  output logic                                out_patch_width,
  output logic [1:0]                          out_kind,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [brp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [brp_pkg::ADDR_W-1:0]     cfg_data
);

  logic [brp_pkg::ADDR_W-1:0] load_address_r;
  logic [brp_pkg::ADDR_W-1:0] preferred_base_r;
  logic                       in_accept;
  logic                       push;
  logic                       pop;
  brp_pkg::brp_cmd_t          push_cmd;
  brp_pkg::brp_cmd_t          head_cmd;
  brp_pkg::brp_qstat_t        qstat;

  assign cfg_ready = 1'b1;
  assign in_stall  = qstat.full;
  assign in_accept = in_valid && !in_stall;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_address_r   <= '0;
      preferred_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        brp_pkg::CFG_LOAD_ADDRESS: begin
          load_address_r <= cfg_data;
        end
        brp_pkg::CFG_PREFERRED_BASE: begin
          preferred_base_r <= cfg_data;
        end
        default: begin
          load_address_r <= load_address_r;
        end
      endcase
    end
  end

  // Parser.
  brp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .halfword (in_halfword),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue.
  brp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (qstat)
  );

  // Executor and output register.
  brp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_cmd          (head_cmd),
    .qstat             (qstat),
    .pop               (pop),
    .load_address      (load_address_r),
    .preferred_base    (preferred_base_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_patch_address (out_patch_address),
    .out_addend        (out_addend),
    .out_patch_width   (out_patch_width),
    .out_kind          (out_kind)
  );

endmodule

`default_nettype wire

// File: design/brp_queue.sv
// Small FIFO of parser commands between the front and the back of the patcher.
// Depends on brp_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module brp_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire brp_pkg::brp_cmd_t      push_cmd,
  input  wire logic                   pop,
  output brp_pkg::brp_cmd_t           head_cmd,
  output brp_pkg::brp_qstat_t         stat
);

  brp_pkg::brp_cmd_t                 slots_r [brp_pkg::Q_DEPTH];
  logic [brp_pkg::Q_PTR_W-1:0]       wr_ptr_r;
  logic [brp_pkg::Q_PTR_W-1:0]       rd_ptr_r;
  logic [brp_pkg::Q_CNT_W-1:0]       count_r;
  logic [brp_pkg::Q_CNT_W-1:0]       count_nxt;

  // Status and head of the queue.
  assign stat.full  = (count_r == brp_pkg::Q_CNT_W'(brp_pkg::Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_cmd   = slots_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  // The occupancy never goes past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= brp_pkg::Q_CNT_W'(brp_pkg::Q_DEPTH))
    else $error("queue occupancy beyond depth");

  // A pop is only issued when something is stored.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: design/brp_front.sv
// Parser: walks block headers and entries and classifies each halfword.
// Depends on brp_pkg; pushes commands into brp_queue.
`timescale 1ns / 1ps
`default_nettype none

module brp_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [brp_pkg::HW_W-1:0]   halfword,
  output logic                            push,
  output brp_pkg::brp_cmd_t               push_cmd
);

  typedef enum logic [2:0] {
    PH_PAGE_LO,
    PH_PAGE_HI,
    PH_SIZE_LO,
    PH_SIZE_HI,
    PH_ENTRY
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [brp_pkg::ADDR_W-1:0]     page_r, page_nxt;
  logic [brp_pkg::HW_W-1:0]       size_lo_r, size_lo_nxt;
  logic [brp_pkg::LEFT_W-1:0]     left_r, left_nxt;
  logic                           done_r, done_nxt;
  logic [brp_pkg::ADDR_W-1:0]     size;
  logic [brp_pkg::LEFT_W-1:0]     left_dec;
  logic [3:0]                     entry_type;

  assign size       = {halfword, size_lo_r};
  assign left_dec   = left_r - 1'b1;
  assign entry_type = halfword[15:12];

  // Next state and the request for the back end.
  always_comb begin
    phase_nxt       = phase_r;
    page_nxt        = page_r;
    size_lo_nxt     = size_lo_r;
    left_nxt        = left_r;
    done_nxt        = done_r;
    push            = 1'b0;
    push_cmd.kind   = brp_pkg::KIND_PATCH;
    push_cmd.cls    = brp_pkg::CLS_WIDE;
    push_cmd.offset = halfword[brp_pkg::OFFSET_W-1:0];
    push_cmd.page   = page_r;
    if (accept && !done_r) begin
      case (phase_r)
        PH_PAGE_LO: begin
          page_nxt  = {16'h0000, halfword};
          phase_nxt = PH_PAGE_HI;
        end
        PH_PAGE_HI: begin
          page_nxt  = {halfword, page_r[15:0]};
          phase_nxt = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          size_lo_nxt = halfword;
          phase_nxt   = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          if (size == '0) begin
            done_nxt      = 1'b1;
            push          = 1'b1;
            push_cmd.kind = brp_pkg::KIND_END;
          end else if (size[31:3] == '0 || size[0]) begin
            done_nxt      = 1'b1;
            push          = 1'b1;
            push_cmd.kind = brp_pkg::KIND_BAD;
          end else begin
            // Entries are (size - 8) / 2 halfwords.
            left_nxt  = size[31:1] - 31'd4;
            phase_nxt = (size[31:1] == 31'd4) ? PH_PAGE_LO : PH_ENTRY;
          end
        end
        PH_ENTRY: begin
          left_nxt = left_dec;
          if (left_dec == '0) begin
            phase_nxt = PH_PAGE_LO;
          end
          case (entry_type)
            brp_pkg::TYPE_HIGH: begin
              push         = 1'b1;
              push_cmd.cls = brp_pkg::CLS_HIGH;
            end
            brp_pkg::TYPE_LOW: begin
              push         = 1'b1;
              push_cmd.cls = brp_pkg::CLS_LOW;
            end
            brp_pkg::TYPE_HIGHLOW, brp_pkg::TYPE_DIR64: begin
              push         = 1'b1;
              push_cmd.cls = brp_pkg::CLS_WIDE;
            end
            default: begin
              push = 1'b0;
            end
          endcase
        end
        default: begin
          phase_nxt = PH_PAGE_LO;
        end
      endcase
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PAGE_LO;
      page_r    <= '0;
      size_lo_r <= '0;
      left_r    <= '0;
      done_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      page_r    <= page_nxt;
      size_lo_r <= size_lo_nxt;
      left_r    <= left_nxt;
      done_r    <= done_nxt;
    end
  end

  // Once the table has ended, no further request leaves the parser.
  a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !push)
    else $error("request issued after end of table");

endmodule

`default_nettype wire

// File: design/brp_back.sv
// Executor: turns queued commands into patch results in an output register.
// Depends on brp_pkg; reads commands from brp_queue.
`timescale 1ns / 1ps
`default_nettype none

module brp_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire brp_pkg::brp_cmd_t           head_cmd,
  input  wire brp_pkg::brp_qstat_t         qstat,
  output logic                             pop,
  input  wire logic [brp_pkg::ADDR_W-1:0]  load_address,
  input  wire logic [brp_pkg::ADDR_W-1:0]  preferred_base,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [brp_pkg::ADDR_W-1:0]       out_patch_address,
  output logic [brp_pkg::ADDR_W-1:0]       out_addend,
  output logic                             out_patch_width,
  output logic [1:0]                       out_kind
);

  logic                        valid_r;
  logic [brp_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [brp_pkg::ADDR_W-1:0]  addend_r, addend_nxt;
  logic                        width_r, width_nxt;
  logic [1:0]                  kind_r;
  logic [brp_pkg::ADDR_W-1:0]  delta;

  // Take the next request when the output register is free or draining.
  assign pop   = !qstat.empty && (!valid_r || !out_stall);
  assign delta = load_address - preferred_base;

  // Patch address, addend and width for the head request.
  always_comb begin
    addr_nxt   = '0;
    addend_nxt = '0;
    width_nxt  = 1'b0;
    if (head_cmd.kind == brp_pkg::KIND_PATCH) begin
      addr_nxt = load_address + head_cmd.page
               + {{(brp_pkg::ADDR_W - brp_pkg::OFFSET_W){1'b0}}, head_cmd.offset};
      case (head_cmd.cls)
        brp_pkg::CLS_HIGH: begin
          addend_nxt = {16'h0000, delta[31:16]};
        end
        brp_pkg::CLS_LOW: begin
          addend_nxt = {16'h0000, delta[15:0]};
        end
        brp_pkg::CLS_WIDE: begin
          addend_nxt = delta;
          width_nxt  = 1'b1;
        end
        default: begin
          addend_nxt = '0;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      addr_r   <= addr_nxt;
      addend_r <= addend_nxt;
      width_r  <= width_nxt;
      kind_r   <= head_cmd.kind;
    end
  end

  assign out_valid         = valid_r;
  assign out_patch_address = addr_r;
  assign out_addend        = addend_r;
  assign out_patch_width   = width_r;
  assign out_kind          = kind_r;

  // End results carry zero fields.
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != brp_pkg::KIND_PATCH)
      |-> (addr_r == '0 && addend_r == '0 && !width_r))
    else $error("end result with nonzero fields");

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for base_relocation_patcher_core: streams relocation
// table halfwords, predicts every patch request in a scoreboard class and checks
// the output channel. Depends on brp_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CLK_HALF      = 1;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned IDLE_PCT      = 15;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 60;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned PHASE_WORDS   = 175;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned WATCHDOG_NS   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;

  // Entry type that never relocates, and register indexes the block ignores.
  localparam logic [3:0]                    TYPE_ABSOLUTE = 4'd0;
  localparam logic [brp_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO  = 2'd2;
  localparam logic [brp_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI  = 2'd3;

  typedef enum logic [2:0] {
    HDR_PAGE_LO,
    HDR_PAGE_HI,
    HDR_SIZE_LO,
    HDR_SIZE_HI,
    HDR_ENTRIES
  } hdr_phase_t;

  // One request on the output channel.
  typedef struct packed {
    logic [brp_pkg::ADDR_W-1:0] address;
    logic [brp_pkg::ADDR_W-1:0] addend;
    logic                       wide;
    logic [1:0]                 kind;
  } patch_t;

  // Tracks the table walk and holds the patch requests still due from the core.
  class reloc_tracker_t;
    logic [brp_pkg::ADDR_W-1:0] load_addr;
    logic [brp_pkg::ADDR_W-1:0] pref_base;
    hdr_phase_t                 phase;
    logic [brp_pkg::ADDR_W-1:0] page;
    logic [brp_pkg::HW_W-1:0]   size_lo;
    logic [brp_pkg::LEFT_W-1:0] left;
    bit                         table_over;
    patch_t                     due_patches[$];
    int unsigned                errors, patches, skipped, blocks, ignored, checked;
    string                      end_note;

    function new();
      load_addr  = '0;
      pref_base  = '0;
      phase      = HDR_PAGE_LO;
      page       = '0;
      size_lo    = '0;
      left       = '0;
      table_over = 1'b0;
      end_note   = "table never ended";
    endfunction

    function void write_reg(logic [brp_pkg::CFG_IDX_W-1:0] idx,
                            logic [brp_pkg::ADDR_W-1:0] data);
      if (idx == brp_pkg::CFG_LOAD_ADDRESS) load_addr = data;
      else if (idx == brp_pkg::CFG_PREFERRED_BASE) pref_base = data;
    endfunction

    function void push(logic [brp_pkg::ADDR_W-1:0] address,
                       logic [brp_pkg::ADDR_W-1:0] addend,
                       logic wide, logic [1:0] kind);
      patch_t p;
      p.address = address;
      p.addend  = addend;
      p.wide    = wide;
      p.kind    = kind;
      due_patches.push_back(p);
    endfunction

    // Advance the walk by one accepted halfword.
    function void take_halfword(logic [brp_pkg::HW_W-1:0] hw);
      logic [brp_pkg::ADDR_W-1:0] size, delta, address;
      logic [3:0]                 etype;
      if (table_over) begin
        ignored++;
        return;
      end
      case (phase)
        HDR_PAGE_LO: begin
          page  = {16'h0, hw};
          phase = HDR_PAGE_HI;
        end
        HDR_PAGE_HI: begin
          page[31:16] = hw;
          phase = HDR_SIZE_LO;
        end
        HDR_SIZE_LO: begin
          size_lo = hw;
          phase = HDR_SIZE_HI;
        end
        HDR_SIZE_HI: begin
          size = {hw, size_lo};
          if (size == 0) begin
            table_over = 1'b1;
            end_note = "zero block size";
            push('0, '0, 1'b0, brp_pkg::KIND_END);
          end else if (size < 8 || size[0]) begin
            table_over = 1'b1;
            end_note = "malformed block size";
            push('0, '0, 1'b0, brp_pkg::KIND_BAD);
          end else begin
            left  = brp_pkg::LEFT_W'((size - 32'd8) >> 1);
            phase = (left != 0) ? HDR_ENTRIES : HDR_PAGE_LO;
            blocks++;
          end
        end
        default: begin
          left = left - 1'b1;
          if (left == 0) phase = HDR_PAGE_LO;
          etype   = hw[15:12];
          delta   = load_addr - pref_base;
          address = load_addr + page + {20'h0, hw[11:0]};
          case (etype)
            brp_pkg::TYPE_HIGH:
              push(address, {16'h0, delta[31:16]}, 1'b0, brp_pkg::KIND_PATCH);
            brp_pkg::TYPE_LOW:
              push(address, {16'h0, delta[15:0]}, 1'b0, brp_pkg::KIND_PATCH);
            brp_pkg::TYPE_HIGHLOW, brp_pkg::TYPE_DIR64:
              push(address, delta, 1'b1, brp_pkg::KIND_PATCH);
            default:
              skipped++;
          endcase
          if (etype == brp_pkg::TYPE_HIGH || etype == brp_pkg::TYPE_LOW ||
              etype == brp_pkg::TYPE_HIGHLOW || etype == brp_pkg::TYPE_DIR64) patches++;
        end
      endcase
    endfunction

    // Compare one request from the core with the oldest one due.
    function void check_patch(patch_t got);
      patch_t want;
      checked++;
      if (due_patches.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected request: addr=%h addend=%h wide=%0d kind=%0d",
                   $time, got.address, got.addend, got.wide, got.kind);
        return;
      end
      want = due_patches.pop_front();
      if (got.address !== want.address || got.addend !== want.addend ||
          got.wide !== want.wide || got.kind !== want.kind) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] mismatch: expected addr=%h addend=%h wide=%0d kind=%0d, %s",
                   $time, want.address, want.addend, want.wide, want.kind,
                   $sformatf("got addr=%h addend=%h wide=%0d kind=%0d",
                             got.address, got.addend, got.wide, got.kind));
      end
    endfunction

    function int unsigned outstanding();
      return due_patches.size();
    endfunction
  endclass

  logic                             clk         = 1'b0;
  logic                             rst_n       = 1'b0;
  logic                             in_valid    = 1'b0;
  logic [brp_pkg::HW_W-1:0]         in_halfword = '0;
  logic                             out_stall   = 1'b0;
  logic                             cfg_valid   = 1'b0;
  logic [brp_pkg::CFG_IDX_W-1:0]    cfg_index   = brp_pkg::CFG_LOAD_ADDRESS;
  logic [brp_pkg::ADDR_W-1:0]       cfg_data    = '0;
  wire                              in_stall;
  wire                              out_valid;
  wire  [brp_pkg::ADDR_W-1:0]       out_patch_address;
  wire  [brp_pkg::ADDR_W-1:0]       out_addend;
  wire                              out_patch_width;
  wire  [1:0]                       out_kind;
  wire                              cfg_ready;

  reloc_tracker_t           tables;
  logic [brp_pkg::HW_W-1:0] table_words[$];
  bit                       calm          = 1'b0;
  int unsigned              hold_req_cnt  = 0;
  int unsigned              hold_done_cnt = 0;
  int unsigned              hold_left     = 0;
  int unsigned              in_held       = 0;
  int unsigned              words_sent    = 0;

  base_relocation_patcher_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_halfword       (in_halfword),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_patch_address (out_patch_address),
    .out_addend        (out_addend),
    .out_patch_width   (out_patch_width),
    .out_kind          (out_kind),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Receiver: random stalls, long hold-offs on request, none while calm.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done_cnt != hold_req_cnt) begin
      hold_done_cnt <= hold_req_cnt;
      hold_left     <= HOLD_CYCLES;
      out_stall     <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tables.check_patch({out_patch_address, out_addend, out_patch_width, out_kind});
      if (in_valid && in_stall) in_held++;
    end
  end

  // Offer one halfword, idling at random first, and note it once accepted.
  task automatic send_word(input logic [brp_pkg::HW_W-1:0] hw);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_halfword <= hw;
    do @(posedge clk); while (in_stall);
    tables.take_halfword(hw);
    words_sent++;
  endtask

  task automatic write_reg(input logic [brp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [brp_pkg::ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tables.write_reg(idx, data);
  endtask

  // Both registers plus a write to an unused index, which must change nothing.
  task automatic program_regs(input logic [brp_pkg::ADDR_W-1:0] load,
                              input logic [brp_pkg::ADDR_W-1:0] pref);
    write_reg(brp_pkg::CFG_LOAD_ADDRESS, load);
    write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
    write_reg(brp_pkg::CFG_PREFERRED_BASE, pref);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and wait until every due request has come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (tables.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [brp_pkg::HW_W-1:0] random_entry();
    logic [3:0] etype;
    case ($urandom_range(9))
      0, 1:    etype = brp_pkg::TYPE_HIGH;
      2, 3:    etype = brp_pkg::TYPE_LOW;
      4, 5:    etype = brp_pkg::TYPE_HIGHLOW;
      6:       etype = brp_pkg::TYPE_DIR64;
      7:       etype = TYPE_ABSOLUTE;
      default: etype = 4'($urandom);
    endcase
    return {etype, 12'($urandom)};
  endfunction

  // Queue a header for the given page and size.
  task automatic queue_header(input logic [brp_pkg::ADDR_W-1:0] page,
                              input logic [brp_pkg::ADDR_W-1:0] size);
    table_words.push_back(page[15:0]);
    table_words.push_back(page[31:16]);
    table_words.push_back(size[15:0]);
    table_words.push_back(size[31:16]);
  endtask

  // Queue one well-formed block, mostly short, now and then a long one.
  task automatic queue_block();
    int unsigned                n;
    logic [brp_pkg::ADDR_W-1:0] page;
    n    = ($urandom_range(19) == 0) ? $urandom_range(60) : $urandom_range(12);
    page = ($urandom_range(3) == 0) ? (32'hFFFF_F000 | 32'($urandom_range(4095)))
                                    : 32'($urandom);
    queue_header(page, 32'd8 + 32'(2 * n));
    repeat (n) table_words.push_back(random_entry());
  endtask

  initial begin
    logic [brp_pkg::ADDR_W-1:0] load, pref, size;
    tables = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: wrapping addresses, every entry type, an empty block.
    program_regs(32'hFFFF_FFFF, 32'h0000_0001);
    queue_header(32'hFFFF_F000, 32'd24);
    table_words.push_back({brp_pkg::TYPE_HIGH, 12'hFFF});
    table_words.push_back({brp_pkg::TYPE_LOW, 12'h000});
    table_words.push_back({brp_pkg::TYPE_HIGHLOW, 12'hABC});
    table_words.push_back({brp_pkg::TYPE_DIR64, 12'h123});
    table_words.push_back({TYPE_ABSOLUTE, 12'h000});
    table_words.push_back(16'hFFFF);
    table_words.push_back(16'h4555);
    table_words.push_back(16'h9FFF);
    queue_header(32'h0000_0000, 32'd8);
    queue_header(32'h1234_5678, 32'd10);
    table_words.push_back({brp_pkg::TYPE_HIGHLOW, 12'h000});
    while (table_words.size() != 0) send_word(table_words.pop_front());

    // Random phases; each boundary may fall in the middle of a block.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0:       begin load = 32'h0000_0000; pref = 32'h0000_0000; end
        1:       begin load = 32'hFFFF_FFFF; pref = 32'h0000_0000; end
        2:       begin load = 32'h0000_0000; pref = 32'hFFFF_FFFF; end
        3:       begin load = 32'hFFFF_FFFF; pref = 32'hFFFF_FFFF; end
        4:       begin load = 32'h0040_0000; pref = 32'h1000_0000; end
        default: begin load = $urandom; pref = $urandom; end
      endcase
      program_regs(load, pref);
      calm = (ph == 3);
      if (ph == 2 || ph == 6) hold_req_cnt++;
      repeat (PHASE_WORDS) begin
        if (table_words.size() == 0) queue_block();
        send_word(table_words.pop_front());
      end
    end
    calm = 1'b0;

    // Finish the open block, end the table, then a few halfwords to be ignored.
    while (table_words.size() != 0) send_word(table_words.pop_front());
    case ($urandom_range(2))
      0:       size = 32'd0;
      1:       size = 32'($urandom_range(1, 7));
      default: size = {16'($urandom), 16'($urandom) | 16'h0001};
    endcase
    queue_header($urandom, size);
    repeat (6) table_words.push_back(16'($urandom));
    while (table_words.size() != 0) send_word(table_words.pop_front());
    in_valid <= 1'b0;

    for (int k = 0; k < DRAIN_LIMIT && tables.outstanding() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (tables.outstanding() != 0)
      $display("%0d expected requests never arrived", tables.outstanding());
    $display("Sent %0d halfwords in %0d blocks: %0d patches, %0d skipped, %0d ignored.",
             words_sent, tables.blocks, tables.patches, tables.skipped, tables.ignored);
    $display("Checked %0d requests over %0d register settings; end by %s; input held %0d cycles.",
             tables.checked, NUM_PHASES + 1, tables.end_note, in_held);
    if (tables.errors == 0 && tables.outstanding() == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", tables.errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #WATCHDOG_NS;
    $display("timeout");
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// File: base_relocation_patcher_core.f
design/brp_pkg.sv
design/brp_queue.sv
design/brp_front.sv
design/brp_back.sv
design/base_relocation_patcher_core.sv
test/testbench.sv
